FILE: sv/ppog_pkg.sv
// Package for the progressive pixel order generator.
// Holds the field widths, the order state and result types, and the bit-length helper.
// No dependencies.
package ppog_pkg;

  localparam int MAX_DIM  = 4096;
  localparam int DIM_W    = 13;
  localparam int COORD_W  = 12;
  localparam int BLOCK_W  = 14;
  localparam int EXP_W    = 4;
  localparam int GRID_W   = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [DIM_W-1:0] DIM_RESET = 13'd64;
  localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIM);

  typedef struct packed {
    logic               in_raster;
    logic               top_due;     // first item of the order still due
    logic [EXP_W-1:0]   lvl_exp;     // log2 of the current level size
    logic [GRID_W-1:0]  grid_col;
    logic [GRID_W-1:0]  grid_row;
    logic [COORD_W-1:0] raster_col;
    logic [COORD_W-1:0] raster_row;
  } order_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [BLOCK_W-1:0] block_size;
    logic               refining;
  } pixel_res_t;

  localparam order_state_t STATE_RESET = '{
    in_raster:  1'b0,
    top_due:    1'b1,
    lvl_exp:    '0,
    grid_col:   '0,
    grid_row:   '0,
    raster_col: '0,
    raster_row: '0
  };

  // Number of significant bits of v (0 for zero).
  function automatic logic [EXP_W-1:0] bit_len(input logic [DIM_W-1:0] v);
    logic [EXP_W-1:0] n;
    n = '0;
    for (int b = 0; b < DIM_W; b++) begin
      if (v[b]) n = EXP_W'(b + 1);
    end
    return n;
  endfunction

endpackage

FILE: sv/ppog_in_if.sv
// Input channel of the progressive pixel order generator: valid/ready plus restart.
// Depends on nothing.
interface ppog_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

FILE: sv/ppog_out_if.sv
// Result channel of the progressive pixel order generator: valid/ready plus pixel fields.
// Depends on nothing.
interface ppog_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [13:0] block_size;
  logic        refining;

  modport source (output valid, output pixel_x, output pixel_y, output block_size,
                  output refining, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input block_size,
                input refining, output ready);
endinterface

FILE: sv/ppog_step.sv
// Next-item logic of the progressive pixel order: from the current order state,
// the restart flag and the image size, gives the result item and the next state. Uses ppog_pkg.
module ppog_step (
  input  ppog_pkg::order_state_t     cur_state,
  input  logic                       restart,
  input  logic [ppog_pkg::DIM_W-1:0] image_width,
  input  logic [ppog_pkg::DIM_W-1:0] image_height,
  output ppog_pkg::order_state_t     nxt_state,
  output ppog_pkg::pixel_res_t       result
);
  import ppog_pkg::*;

  order_state_t       s;
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [COORD_W-1:0] wm1, hm1, dmax;
  logic [COORD_W-1:0] imax, jmax;
  logic [GRID_W-1:0]  i_cur, j_cur, i_p1, i_p2, j_p1, j_odd;
  logic [EXP_W-1:0]   e_cur, e_half, p_exp, e_dn, top_exp;
  logic               raster_go;
  logic               go_down;
  logic [GRID_W-1:0]  i_nx, j_nx;
  logic [COORD_W-1:0] lv_dn;
  logic               fresh_raster;
  logic [COORD_W-1:0] rc_b, rr_b;
  logic [COORD_W:0]   rr_inc, rc_inc;
  logic [COORD_W-1:0] rc_n, rr_n;

  always_comb begin
    w_eff = (image_width == '0) ? DIM_W'(1) : ((image_width > DIM_MAX) ? DIM_MAX : image_width);
    h_eff = (image_height == '0) ? DIM_W'(1)
          : ((image_height > DIM_MAX) ? DIM_MAX : image_height);
    wm1   = COORD_W'(w_eff - DIM_W'(1));
    hm1   = COORD_W'(h_eff - DIM_W'(1));
    dmax  = (wm1 > hm1) ? wm1 : hm1;
    top_exp = bit_len((w_eff > h_eff) ? w_eff : h_eff);

    s = restart ? STATE_RESET : cur_state;

    e_cur = s.lvl_exp;
    i_cur = s.grid_col;
    j_cur = s.grid_row;
    imax  = wm1 >> e_cur;
    jmax  = hm1 >> e_cur;
    i_p1  = i_cur + GRID_W'(1);
    i_p2  = i_cur + GRID_W'(2);
    j_p1  = j_cur + GRID_W'(1);
    j_odd = j_p1 | GRID_W'(1);

    // step within the level, skipping points with both indices even
    go_down = 1'b0;
    i_nx    = i_cur;
    j_nx    = j_cur;
    if (i_cur > {1'b0, imax}) begin
      go_down = 1'b1;
    end else if (i_cur[0]) begin
      if (j_p1 <= {1'b0, jmax}) begin
        j_nx = j_p1;
      end else if (jmax != '0) begin
        if (i_p1 <= {1'b0, imax}) begin
          i_nx = i_p1;
          j_nx = GRID_W'(1);
        end else begin
          go_down = 1'b1;
        end
      end else begin
        if (i_p2 <= {1'b0, imax}) begin
          i_nx = i_p2;
          j_nx = '0;
        end else begin
          go_down = 1'b1;
        end
      end
    end else begin
      if (j_odd <= {1'b0, jmax}) begin
        j_nx = j_odd;
      end else if (i_p1 <= {1'b0, imax}) begin
        i_nx = i_p1;
        j_nx = '0;
      end else begin
        go_down = 1'b1;
      end
    end

    // next nonempty level below the current one
    e_half    = e_cur - EXP_W'(1);
    p_exp     = bit_len({1'b0, dmax}) - EXP_W'(1);
    raster_go = (e_cur == '0) || (dmax == '0);
    e_dn      = (e_half < p_exp) ? e_half : p_exp;
    lv_dn     = COORD_W'(1) << e_dn;

    // raster pass
    fresh_raster = !s.in_raster;
    if (fresh_raster || ({1'b0, s.raster_col} >= w_eff) || ({1'b0, s.raster_row} >= h_eff)) begin
      rc_b = '0;
      rr_b = '0;
    end else begin
      rc_b = s.raster_col;
      rr_b = s.raster_row;
    end
    rr_inc = {1'b0, rr_b} + (COORD_W+1)'(1);
    rc_inc = {1'b0, rc_b} + (COORD_W+1)'(1);
    if (rr_inc >= h_eff) begin
      rr_n = '0;
      rc_n = (rc_inc >= w_eff) ? '0 : rc_inc[COORD_W-1:0];
    end else begin
      rr_n = rr_inc[COORD_W-1:0];
      rc_n = rc_b;
    end

    nxt_state = s;
    result    = '0;
    if (s.in_raster || (!s.top_due && go_down && raster_go)) begin
      nxt_state            = STATE_RESET;
      nxt_state.in_raster  = 1'b1;
      nxt_state.top_due    = 1'b0;
      nxt_state.raster_col = rc_n;
      nxt_state.raster_row = rr_n;
      result.pixel_x       = rc_b;
      result.pixel_y       = rr_b;
      result.block_size    = BLOCK_W'(1);
      result.refining      = 1'b0;
    end else if (s.top_due) begin
      nxt_state.top_due  = 1'b0;
      nxt_state.lvl_exp  = top_exp;
      nxt_state.grid_col = '0;
      nxt_state.grid_row = '0;
      result.block_size  = BLOCK_W'(1) << top_exp;
      result.refining    = 1'b1;
    end else begin
      if (go_down) begin
        nxt_state.lvl_exp = e_dn;
        if (hm1 >= lv_dn) begin
          nxt_state.grid_col = '0;
          nxt_state.grid_row = GRID_W'(1);
        end else begin
          nxt_state.grid_col = GRID_W'(1);
          nxt_state.grid_row = '0;
        end
      end else begin
        nxt_state.grid_col = i_nx;
        nxt_state.grid_row = j_nx;
      end
      result.pixel_x    = nxt_state.grid_col[COORD_W-1:0] << nxt_state.lvl_exp;
      result.pixel_y    = nxt_state.grid_row[COORD_W-1:0] << nxt_state.lvl_exp;
      result.block_size = BLOCK_W'(1) << nxt_state.lvl_exp;
      result.refining   = 1'b1;
    end
  end

endmodule

FILE: sv/progressive_pixel_order_generator.sv
// Progressive pixel order generator: coarse-to-fine sample order, then raster passes.
// Latency: the result of an accepted item is valid on the next cycle.
// Throughput: one item per cycle; in_ch.ready is high while the result register
// is empty or its item is taken in the same cycle.
// Reset (rst_n, synchronous, active low): image size 64 x 64, no result pending,
// and the next item yields the first sample of the order.
// Uses ppog_pkg, ppog_in_if, ppog_out_if and ppog_step.
module progressive_pixel_order_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  ppog_in_if.sink                        in_ch,
  ppog_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [ppog_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppog_pkg::DIM_W-1:0]     cfg_wdata
);
  import ppog_pkg::*;

  order_state_t     state_r, state_nxt;
  pixel_res_t       res_r, res_nxt;
  logic             out_valid_r;
  logic [DIM_W-1:0] width_r, height_r;
  logic             in_acc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  ppog_step u_step (
    .cur_state    (state_r),
    .restart      (in_ch.restart),
    .image_width  (width_r),
    .image_height (height_r),
    .nxt_state    (state_nxt),
    .result       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
      width_r     <= DIM_RESET;
      height_r    <= DIM_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
          REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_x    = res_r.pixel_x;
  assign out_ch.pixel_y    = res_r.pixel_y;
  assign out_ch.block_size = res_r.block_size;
  assign out_ch.refining   = res_r.refining;

  a_restart_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.restart |=> out_valid_r && res_r.refining &&
      res_r.pixel_x == '0 && res_r.pixel_y == '0)
    else $error("restart item did not yield the first sample");

  a_raster_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.refining |-> res_r.block_size == BLOCK_W'(1))
    else $error("raster item with block size other than one");

  a_block_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot(res_r.block_size))
    else $error("block size not a power of two");

  a_raster_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.in_raster && !(in_acc && in_ch.restart) |=> state_r.in_raster)
    else $error("left raster passes without restart");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(state_r))
    else $error("order state moved without an accepted item");

endmodule

FILE: verif/tb_progressive_pixel_order_generator.sv
`timescale 1ns / 100ps
// Testbench for progressive_pixel_order_generator: random restart items under random
// idling and back-pressure, checked against an in-bench model of the sample order.
// Depends on ppog_pkg, ppog_in_if, ppog_out_if and the generator RTL.
module tb_progressive_pixel_order_generator;
  import ppog_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_wdata;

  ppog_in_if in_ch ();
  ppog_out_if out_ch ();

  progressive_pixel_order_generator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // model copy of the registers and the order state
  logic [DIM_W-1:0] dim_w_reg;
  logic [DIM_W-1:0] dim_h_reg;
  logic ord_in_raster;
  int ord_level;
  int ord_col;
  int ord_row;
  int ras_col;
  int ras_row;

  bit pend_restarts[$];
  pixel_res_t expected_pixels[$];
  pixel_res_t want;
  int failures = 0;
  bit in_taken;
  int gap_left;
  int stall_left;
  bit idle_on = 1'b1;
  bit hold_off = 1'b0;
  bit directed_done = 1'b0;

  function automatic int eff_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic pixel_res_t raster_pixel(input int w, input int h);
    pixel_res_t r;
    if (ras_col >= w || ras_row >= h) begin
      ras_col = 0;
      ras_row = 0;
    end
    r.pixel_x = COORD_W'(ras_col);
    r.pixel_y = COORD_W'(ras_row);
    r.block_size = BLOCK_W'(1);
    r.refining = 1'b0;
    ras_row++;
    if (ras_row >= h) begin
      ras_row = 0;
      ras_col++;
      if (ras_col >= w) ras_col = 0;
    end
    return r;
  endfunction

  function automatic pixel_res_t next_pixel(input logic restart);
    int w;
    int h;
    int m;
    int lv;
    int i;
    int j;
    int imax;
    int jmax;
    bit done;
    pixel_res_t r;
    w = eff_dim(dim_w_reg);
    h = eff_dim(dim_h_reg);
    if (restart) begin
      ord_in_raster = 1'b0;
      ord_level = 0;
      ord_col = 0;
      ord_row = 0;
      ras_col = 0;
      ras_row = 0;
    end
    if (ord_in_raster) return raster_pixel(w, h);
    if (ord_level == 0) begin
      // top size: two to the power of the bit length of the larger side
      m = (w > h) ? w : h;
      lv = 1;
      while (m > 0) begin
        lv = lv << 1;
        m = m >> 1;
      end
      ord_level = lv;
      ord_col = 0;
      ord_row = 0;
      r.pixel_x = '0;
      r.pixel_y = '0;
      r.block_size = BLOCK_W'(lv);
      r.refining = 1'b1;
      return r;
    end
    lv = ord_level;
    i = ord_col;
    j = ord_row;
    done = 1'b0;
    while (!done) begin
      imax = (w - 1) / lv;
      jmax = (h - 1) / lv;
      j++;
      if (j > jmax) begin
        j = 0;
        i++;
      end
      if (i > imax) begin
        i = 0;
        j = 0;
        lv = lv >> 1;
        if (lv == 0) done = 1'b1;
      end else if (((i | j) & 1) != 0) begin
        done = 1'b1;
      end
    end
    if (lv == 0) begin
      ord_in_raster = 1'b1;
      ord_level = 0;
      ord_col = 0;
      ord_row = 0;
      ras_col = 0;
      ras_row = 0;
      return raster_pixel(w, h);
    end
    ord_level = lv;
    ord_col = i;
    ord_row = j;
    r.pixel_x = COORD_W'(i * lv);
    r.pixel_y = COORD_W'(j * lv);
    r.block_size = BLOCK_W'(lv);
    r.refining = 1'b1;
    return r;
  endfunction

  // input side: acceptance and prediction at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_ch.valid && in_ch.ready;
      if (in_taken) begin
        expected_pixels.push_back(next_pixel(in_ch.restart));
      end
    end
  end

  // input side: drive at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.restart <= 1'b0;
      gap_left = 0;
    end else if (!(in_ch.valid && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pend_restarts.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.restart <= pend_restarts.pop_front();
        gap_left = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side: check at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("result with none expected: x %0d y %0d size %0d refining %0d",
               out_ch.pixel_x, out_ch.pixel_y, out_ch.block_size, out_ch.refining);
        failures++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_ch.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0d, actual %0d", want.pixel_x, out_ch.pixel_x);
          failures++;
        end
        if (out_ch.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0d, actual %0d", want.pixel_y, out_ch.pixel_y);
          failures++;
        end
        if (out_ch.block_size !== want.block_size) begin
          $error("block_size: expected %0d, actual %0d", want.block_size, out_ch.block_size);
          failures++;
        end
        if (out_ch.refining !== want.refining) begin
          $error("refining: expected %0d, actual %0d", want.refining, out_ch.refining);
          failures++;
        end
      end
    end
  end

  // result side: ready at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // long receiver hold-off while the sender keeps offering items
  initial begin
    while (!(directed_done && pend_restarts.size() > 30)) @(posedge clk);
    hold_off = 1'b1;
    repeat (120) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) dim_w_reg = val;
    else dim_h_reg = val;
  endtask

  task automatic run_phase(input bit set_dims, input logic [DIM_W-1:0] w,
                           input logic [DIM_W-1:0] h, input int n, input bit fresh,
                           input int restart_pct);
    if (set_dims) begin
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
    end
    for (int k = 0; k < n; k++) begin
      pend_restarts.push_back((k == 0 && fresh) || ($urandom_range(0, 99) < restart_pct));
    end
    while (pend_restarts.size() != 0 || in_ch.valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    int total;
    int r;
    int n;
    int ew;
    int eh;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_wdata = '0;
    dim_w_reg = DIM_RESET;
    dim_h_reg = DIM_RESET;
    ord_in_raster = 1'b0;
    ord_level = 0;
    ord_col = 0;
    ord_row = 0;
    ras_col = 0;
    ras_row = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // order right after reset, no restart, reset dimensions
    run_phase(1'b0, '0, '0, 3, 1'b0, 0);
    run_phase(1'b0, '0, '0, 2, 1'b1, 0);
    // zero dimensions act as one
    run_phase(1'b1, 13'd0, 13'd0, 3, 1'b1, 0);
    // oversize width clamps, largest block size
    run_phase(1'b1, 13'd8191, 13'd1, 3, 1'b1, 0);
    // dimensions changed in the middle of the order
    run_phase(1'b1, 13'd16, 13'd16, 5, 1'b1, 0);
    run_phase(1'b1, 13'd5, 13'd3, 5, 1'b0, 0);
    // full refining pass into the raster pass
    run_phase(1'b1, 13'd2, 13'd2, 7, 1'b1, 0);
    directed_done = 1'b1;

    total = 0;
    while (total < 1950) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        w = DIM_W'($urandom_range(1, 12));
        h = DIM_W'($urandom_range(1, 12));
      end else if (r < 85) begin
        w = DIM_W'($urandom_range(1, 40));
        h = DIM_W'($urandom_range(1, 40));
      end else if (r < 93) begin
        case ($urandom_range(0, 3))
          0: w = 13'd0;
          1: w = 13'd4095;
          2: w = 13'd4096;
          default: w = 13'd8191;
        endcase
        h = DIM_W'($urandom_range(1, 4));
        if ($urandom_range(0, 1)) {w, h} = {h, w};
      end else begin
        w = DIM_W'($urandom_range(0, 8191));
        h = DIM_W'($urandom_range(0, 8191));
      end
      ew = eff_dim(w);
      eh = eff_dim(h);
      if (ew * eh <= 200) n = ew * eh + $urandom_range(0, 40);
      else n = $urandom_range(20, 80);
      idle_on = ($urandom_range(0, 3) != 0);
      run_phase(1'b1, w, h, n, $urandom_range(0, 1),
                ($urandom_range(0, 9) == 0) ? 25 : 1);
      total += n;
    end

    repeat (5) @(posedge clk);
    if (failures == 0 && expected_pixels.size() == 0) begin
      $display("tb_progressive_pixel_order_generator: done, clean");
    end else begin
      $display("tb_progressive_pixel_order_generator: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_progressive_pixel_order_generator: done, errors");
    $finish;
  end

endmodule
